FILE: design/lbol_pkg.sv
// Shared types, codes and constants of the log-space bilinear opacity lookup unit.
package lbol_pkg;

	localparam int MATERIAL_SLOTS     = 4;
	localparam int MAX_TEMP_POINTS    = 16;
	localparam int MAX_DENSITY_POINTS = 16;
	localparam int MAX_GROUPS         = 16;

	localparam int MAT_W   = 2;
	localparam int TIDX_W  = 4;
	localparam int DIDX_W  = 4;
	localparam int GIDX_W  = 4;
	localparam int BIDX_W  = 5;
	localparam int TBL_AW  = MAT_W + 2 + GIDX_W + DIDX_W + TIDX_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	localparam logic [27:0] LN2_Q28     = 28'd186065280;
	localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;

	typedef enum logic [1:0] {
		CMD_LOAD_GRID  = 2'd0,
		CMD_LOAD_TABLE = 2'd1,
		CMD_EVAL_ALL   = 2'd2,
		CMD_EVAL_AT    = 2'd3
	} cmd_t;

	localparam logic [2:0] SEL_TEMP_GRID   = 3'd0;
	localparam logic [2:0] SEL_DENS_GRID   = 3'd1;
	localparam logic [2:0] SEL_BOUNDS      = 3'd2;
	localparam logic [2:0] SEL_ROSS_MG     = 3'd3;
	localparam logic [2:0] SEL_PLANCK_MG   = 3'd4;
	localparam logic [2:0] SEL_ROSS_GRAY   = 3'd5;
	localparam logic [2:0] SEL_PLANCK_GRAY = 3'd6;

	localparam logic [1:0] REG_TEMP_POINTS = 2'd0;
	localparam logic [1:0] REG_DENS_POINTS = 2'd1;
	localparam logic [1:0] REG_GROUP_COUNT = 2'd2;

	typedef enum logic [1:0] {
		SRCH_TEMP   = 2'd0,
		SRCH_DENS   = 2'd1,
		SRCH_BOUNDS = 2'd2
	} srch_mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOG_INIT,
		ST_LOG_SQ,
		ST_LOG_MUL,
		ST_LOG_RND,
		ST_GS_FIRST,
		ST_GS_FCHK,
		ST_GS_LCHK,
		ST_GS_SRD,
		ST_GS_SCHK,
		ST_GS_LO,
		ST_GS_HI,
		ST_GS_DEN,
		ST_GS_DIV,
		ST_W_STORE,
		ST_GRP_INIT,
		ST_CN_ADDR,
		ST_CN_MUL,
		ST_CN_ACC,
		ST_EXP_L,
		ST_EXP_MUL,
		ST_EXP_Y,
		ST_EXP_IT,
		ST_EMIT
	} state_t;

	typedef logic [24:1][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] arg);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bit_v;
		x = arg;
		res = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (x >= res + bit_v) begin
				x = x - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Successive square roots of two in Q1.31, used by the exponential.
	function automatic root_tab_t build_roots();
		logic [63:0] c;
		root_tab_t tab;
		c = 64'h1_0000_0000;
		for (int i = 1; i <= 24; i++) begin
			c = isqrt64(c << 31);
			tab[i] = c[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP_ROOTS = build_roots();

endpackage

FILE: design/log_bilinear_opacity_lookup_unit.sv
// Top level of the log-space bilinear opacity lookup unit.
//
//  channel   signals                              direction
//  in        in_valid/in_ready + request fields   into the block
//  out       out_valid/out_ready + result fields  out of the block
//  cfg       cfg_we, cfg_index, cfg_data          into the block, write only
//
// Loads are written to memory in the cycle they are accepted.
// An evaluation runs the two logarithms (one shared squaring multiplier, 24 steps
// each), a scan of grid points and up to 16 divider steps per grid search, a scan
// of the energy bounds for an energy request, then per group the four table reads
// and products and the exponential, one root multiply per cycle.
// Reset clears the control state and sets the configuration registers to 16; the memories
// hold garbage until written. A stalled output holds the sequencer in its emit
// state; a new request is taken as soon as the last result sits in the output register.
module log_bilinear_opacity_lookup_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [1:0]  material,
	input  logic [2:0]  table_select,
	input  logic [4:0]  group,
	input  logic [3:0]  density_index,
	input  logic [3:0]  temp_index,
	input  logic [63:0] load_value,
	input  logic [63:0] density_bits,
	input  logic [63:0] temperature_bits,
	input  logic [63:0] energy_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] opacity_bits,
	output logic [3:0]  group_index,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import lbol_pkg::*;

	state_t state_q, state_d;
	srch_mode_t mode_q;

	logic [4:0] temp_pts_q, dens_pts_q, grp_cnt_q;
	logic [4:0] nt, nd, ng, nsrch;

	logic [1:0]  cmd_q, mat_q;
	logic [2:0]  sel_q;
	logic [63:0] dbits_q, tbits_q, ebits_q;

	logic [31:0] tg_mem [MATERIAL_SLOTS][MAX_TEMP_POINTS];
	logic [31:0] dg_mem [MATERIAL_SLOTS][MAX_DENSITY_POINTS];
	logic [63:0] bd_mem [MATERIAL_SLOTS][MAX_GROUPS+1];
	logic [31:0] tb_mem [TBL_DEPTH];
	logic [31:0] tg_rd_q, dg_rd_q, tb_rd_q;
	logic [63:0] bd_rd_q;
	logic [BIDX_W-1:0] ga;
	logic [TBL_AW-1:0] ta;

	logic        in_fire, eval_ok, gray, energy_srch;
	logic [63:0] src_bits;
	logic        log_special;
	logic [31:0] log_special_val;
	logic [30:0] lm_q;
	logic [61:0] lsq;
	logic [31:0] lsq_t;
	logic [23:0] frac_q;
	logic [4:0]  cnt_q;
	logic signed [12:0] eun;
	logic signed [36:0] l2;
	logic signed [65:0] lp_q, lp_sum;
	logic signed [37:0] lrnd;
	logic [31:0] lsat;
	logic signed [31:0] lt_q, ld_q, vlog, graw;

	logic [63:0] vkey, rkey;
	logic [4:0]  idx_q, id_q;
	logic        found;
	logic [4:0]  found_id;
	logic signed [31:0] lo_q;
	logic signed [32:0] wnum, wden;
	logic        w_zero, w_full;
	logic [33:0] rem_q, rem_sh;
	logic [32:0] den_q;
	logic [15:0] q_q, q_next;
	logic [33:0] rem_next;
	logic [16:0] w_q, xi_q, eta_q;
	logic [3:0]  tid_q, rid_q;

	logic [3:0]  g_q;
	logic [4:0]  gcnt_q, gtot_q;
	logic [1:0]  c_q;
	logic [16:0] wa, wb;
	logic [33:0] wmul;
	logic [32:0] wprod_q;
	logic signed [65:0] pmul;
	logic signed [64:0] prod_q, acc_q, acc_sum;
	logic signed [31:0] l_q;
	logic signed [63:0] emul_q, esum;
	logic signed [32:0] ey_q;
	logic [4:0]  fidx;
	logic [63:0] mmul;
	logic [31:0] m_q;
	logic [10:0] expo;
	logic        emit_ok, grp_last;

	logic        out_valid_q, last_q;
	logic [63:0] opac_q;
	logic [3:0]  gidx_q;

	assign in_fire = in_valid && in_ready;
	assign eval_ok = (command == CMD_EVAL_ALL || command == CMD_EVAL_AT)
		&& table_select >= SEL_ROSS_MG && table_select <= SEL_PLANCK_GRAY;
	assign gray = (sel_q == SEL_ROSS_GRAY) || (sel_q == SEL_PLANCK_GRAY);
	assign energy_srch = (cmd_q == CMD_EVAL_AT) && !gray;

	assign nt = (temp_pts_q < 5'd2) ? 5'd2 : (temp_pts_q > 5'd16) ? 5'd16 : temp_pts_q;
	assign nd = (dens_pts_q < 5'd2) ? 5'd2 : (dens_pts_q > 5'd16) ? 5'd16 : dens_pts_q;
	assign ng = (grp_cnt_q < 5'd1) ? 5'd1 : (grp_cnt_q > 5'd16) ? 5'd16 : grp_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_pts_q <= 5'd16;
			dens_pts_q <= 5'd16;
			grp_cnt_q  <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_POINTS: temp_pts_q <= cfg_data;
				REG_DENS_POINTS: dens_pts_q <= cfg_data;
				REG_GROUP_COUNT: grp_cnt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LOAD_GRID && table_select == SEL_TEMP_GRID) begin
			tg_mem[material][temp_index] <= load_value[31:0];
		end
		tg_rd_q <= tg_mem[mat_q][ga[3:0]];
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LOAD_GRID && table_select == SEL_DENS_GRID) begin
			dg_mem[material][density_index] <= load_value[31:0];
		end
		dg_rd_q <= dg_mem[mat_q][ga[3:0]];
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LOAD_GRID && table_select == SEL_BOUNDS
				&& group <= 5'(MAX_GROUPS)) begin
			bd_mem[material][group] <= load_value;
		end
		bd_rd_q <= bd_mem[mat_q][ga];
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LOAD_TABLE && table_select >= SEL_ROSS_MG
				&& table_select <= SEL_PLANCK_GRAY && group < 5'(MAX_GROUPS)) begin
			tb_mem[{material, 2'(table_select - SEL_ROSS_MG), group[3:0], density_index,
				temp_index}] <= load_value[31:0];
		end
		tb_rd_q <= tb_mem[ta];
	end

	assign src_bits = (mode_q == SRCH_DENS) ? dbits_q : tbits_q;
	assign log_special = src_bits[63] || (src_bits[62:52] == 11'd0) || (src_bits[62:52] == 11'h7FF);
	assign log_special_val = (src_bits[63] || src_bits[62:52] == 11'd0) ? 32'h8000_0000
		: 32'h7FFF_FFFF;
	assign lsq = 62'(lm_q * lm_q);
	assign lsq_t = lsq[61:30];
	assign eun = $signed({2'b00, src_bits[62:52]}) - 13'sd1023;
	assign l2 = $signed({eun, 24'h0}) + $signed({13'h0, frac_q});
	assign lp_sum = lp_q + 66'sd134217728;
	assign lrnd = lp_sum[65:28];
	assign lsat = (lrnd < -38'sd2147483648) ? 32'h8000_0000
		: (lrnd > 38'sd2147483647) ? 32'h7FFF_FFFF : lrnd[31:0];

	assign vlog = (mode_q == SRCH_DENS) ? ld_q : lt_q;
	assign graw = (mode_q == SRCH_DENS) ? dg_rd_q : tg_rd_q;

	always_comb begin
		case (mode_q)
			SRCH_TEMP: begin
				vkey = {~lt_q[31], lt_q[30:0], 32'h0};
				rkey = {~tg_rd_q[31], tg_rd_q[30:0], 32'h0};
				nsrch = nt;
			end
			SRCH_DENS: begin
				vkey = {~ld_q[31], ld_q[30:0], 32'h0};
				rkey = {~dg_rd_q[31], dg_rd_q[30:0], 32'h0};
				nsrch = nd;
			end
			SRCH_BOUNDS: begin
				vkey = ebits_q[63] ? ~ebits_q : {1'b1, ebits_q[62:0]};
				rkey = bd_rd_q[63] ? ~bd_rd_q : {1'b1, bd_rd_q[62:0]};
				nsrch = ng + 5'd1;
			end
			default: begin
				vkey = '0;
				rkey = '0;
				nsrch = nt;
			end
		endcase
	end

	always_comb begin
		found = 1'b0;
		found_id = '0;
		case (state_q)
			ST_GS_FCHK: begin
				found = (vkey <= rkey);
				found_id = '0;
			end
			ST_GS_LCHK: begin
				found = (vkey >= rkey);
				found_id = nsrch - 5'd2;
			end
			ST_GS_SCHK: begin
				found = (rkey >= vkey) || (idx_q == nsrch - 5'd1);
				found_id = idx_q - 5'd1;
			end
			default: ;
		endcase
	end

	assign wnum = $signed({vlog[31], vlog}) - $signed({lo_q[31], lo_q});
	assign wden = $signed({graw[31], graw}) - $signed({lo_q[31], lo_q});
	assign w_zero = (wden <= 33'sd0) || (wnum <= 33'sd0);
	assign w_full = (wnum >= wden);
	assign rem_sh = {rem_q[32:0], 1'b0};
	assign rem_next = (rem_sh >= {1'b0, den_q}) ? rem_sh - {1'b0, den_q} : rem_sh;
	assign q_next = {q_q[14:0], rem_sh >= {1'b0, den_q}};

	assign wa = c_q[0] ? xi_q : 17'(17'h10000 - xi_q);
	assign wb = c_q[1] ? eta_q : 17'(17'h10000 - eta_q);
	assign wmul = 34'(wa * wb);
	assign pmul = $signed(tb_rd_q) * $signed({1'b0, wprod_q});
	assign acc_sum = acc_q + 65'sd2147483648;
	assign esum = emul_q + 64'sd536870912;
	assign fidx = 5'(5'd24 - cnt_q);
	assign mmul = 64'(m_q * EXP_ROOTS[cnt_q]);
	assign expo = 11'({{2{ey_q[32]}}, ey_q[32:24]} + 11'd1023);
	assign emit_ok = !out_valid_q || out_ready;
	assign grp_last = (gcnt_q == gtot_q - 5'd1);

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		ga = '0;
		ta = {mat_q, 2'(sel_q - SEL_ROSS_MG), g_q, 4'(rid_q + {3'b0, c_q[1]}),
			4'(tid_q + {3'b0, c_q[0]})};
		unique case (state_q)
			ST_GS_FCHK: ga = nsrch - 5'd1;
			ST_GS_SRD:  ga = idx_q;
			ST_GS_LO:   ga = id_q;
			ST_GS_HI:   ga = id_q + 5'd1;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_fire && eval_ok) state_d = ST_LOG_INIT;
			ST_LOG_INIT: begin
				if (!log_special) state_d = ST_LOG_SQ;
				else if (mode_q == SRCH_DENS) state_d = ST_GS_FIRST;
			end
			ST_LOG_SQ:   if (cnt_q == 5'd23) state_d = ST_LOG_MUL;
			ST_LOG_MUL:  state_d = ST_LOG_RND;
			ST_LOG_RND:  state_d = (mode_q == SRCH_DENS) ? ST_GS_FIRST : ST_LOG_INIT;
			ST_GS_FIRST: state_d = ST_GS_FCHK;
			ST_GS_FCHK, ST_GS_LCHK, ST_GS_SCHK: begin
				if (found) state_d = (mode_q == SRCH_BOUNDS) ? ST_GRP_INIT : ST_GS_LO;
				else if (state_q == ST_GS_FCHK) state_d = ST_GS_LCHK;
				else state_d = ST_GS_SRD;
			end
			ST_GS_SRD:   state_d = ST_GS_SCHK;
			ST_GS_LO:    state_d = ST_GS_HI;
			ST_GS_HI:    state_d = ST_GS_DEN;
			ST_GS_DEN:   state_d = (w_zero || w_full) ? ST_W_STORE : ST_GS_DIV;
			ST_GS_DIV:   if (cnt_q == 5'd15) state_d = ST_W_STORE;
			ST_W_STORE: begin
				if (mode_q == SRCH_TEMP || energy_srch) state_d = ST_GS_FIRST;
				else state_d = ST_GRP_INIT;
			end
			ST_GRP_INIT: state_d = ST_CN_ADDR;
			ST_CN_ADDR:  state_d = ST_CN_MUL;
			ST_CN_MUL:   state_d = ST_CN_ACC;
			ST_CN_ACC:   state_d = (c_q == 2'd3) ? ST_EXP_L : ST_CN_ADDR;
			ST_EXP_L:    state_d = ST_EXP_MUL;
			ST_EXP_MUL:  state_d = ST_EXP_Y;
			ST_EXP_Y:    state_d = ST_EXP_IT;
			ST_EXP_IT:   if (cnt_q == 5'd24) state_d = ST_EMIT;
			ST_EMIT:     if (emit_ok) state_d = grp_last ? ST_IDLE : ST_CN_ADDR;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd_q   <= command;
					mat_q   <= material;
					sel_q   <= table_select;
					dbits_q <= density_bits;
					tbits_q <= temperature_bits;
					ebits_q <= energy_bits;
					mode_q  <= SRCH_TEMP;
				end
			end
			ST_LOG_INIT: begin
				if (log_special) begin
					if (mode_q == SRCH_DENS) begin
						ld_q <= log_special_val;
						mode_q <= SRCH_TEMP;
					end else begin
						lt_q <= log_special_val;
						mode_q <= SRCH_DENS;
					end
				end
				lm_q <= {1'b1, src_bits[51:22]};
				frac_q <= '0;
				cnt_q <= '0;
			end
			ST_LOG_SQ: begin
				lm_q <= lsq_t[31] ? lsq_t[31:1] : lsq_t[30:0];
				frac_q <= {frac_q[22:0], lsq_t[31]};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_LOG_MUL: lp_q <= l2 * $signed({1'b0, LN2_Q28});
			ST_LOG_RND: begin
				if (mode_q == SRCH_DENS) begin
					ld_q <= lsat;
					mode_q <= SRCH_TEMP;
				end else begin
					lt_q <= lsat;
					mode_q <= SRCH_DENS;
				end
			end
			ST_GS_FCHK, ST_GS_LCHK, ST_GS_SCHK: begin
				if (found) id_q <= found_id;
				if (state_q == ST_GS_SCHK) idx_q <= idx_q + 5'd1;
				else idx_q <= 5'd1;
			end
			ST_GS_HI: lo_q <= graw;
			ST_GS_DEN: begin
				w_q <= w_zero ? 17'd0 : 17'h10000;
				rem_q <= {1'b0, wnum};
				den_q <= wden;
				q_q <= '0;
				cnt_q <= '0;
			end
			ST_GS_DIV: begin
				rem_q <= rem_next;
				q_q <= q_next;
				w_q <= {1'b0, q_next};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_W_STORE: begin
				if (mode_q == SRCH_TEMP) begin
					xi_q <= w_q;
					tid_q <= id_q[3:0];
					mode_q <= SRCH_DENS;
				end else begin
					eta_q <= w_q;
					rid_q <= id_q[3:0];
					if (energy_srch) mode_q <= SRCH_BOUNDS;
				end
			end
			ST_GRP_INIT: begin
				g_q <= (mode_q == SRCH_BOUNDS) ? id_q[3:0] : 4'd0;
				gcnt_q <= '0;
				gtot_q <= (cmd_q == CMD_EVAL_ALL && !gray) ? ng : 5'd1;
				acc_q <= '0;
				c_q <= '0;
			end
			ST_CN_ADDR: wprod_q <= wmul[32:0];
			ST_CN_MUL:  prod_q <= pmul[64:0];
			ST_CN_ACC: begin
				acc_q <= acc_q + prod_q;
				c_q <= c_q + 2'd1;
			end
			ST_EXP_L:   l_q <= acc_sum[63:32];
			ST_EXP_MUL: emul_q <= l_q * $signed({1'b0, INV_LN2_Q30});
			ST_EXP_Y: begin
				ey_q <= esum[62:30];
				m_q <= 32'h8000_0000;
				cnt_q <= 5'd1;
			end
			ST_EXP_IT: begin
				if (ey_q[fidx]) m_q <= mmul[62:31];
				cnt_q <= cnt_q + 5'd1;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					opac_q <= {1'b0, expo, m_q[30:0], 21'h0};
					gidx_q <= g_q;
					last_q <= grp_last;
					g_q <= g_q + 4'd1;
					gcnt_q <= gcnt_q + 5'd1;
					acc_q <= '0;
					c_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign opacity_bits = opac_q;
	assign group_index = gidx_q;
	assign last = last_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the log-space bilinear opacity lookup unit.
module testbench;
	import lbol_pkg::*;

	typedef struct {
		cmd_t        command;
		logic [1:0]  material;
		logic [2:0]  table_select;
		logic [4:0]  group;
		logic [3:0]  density_index;
		logic [3:0]  temp_index;
		logic [63:0] load_value;
		logic [63:0] density_bits;
		logic [63:0] temperature_bits;
		logic [63:0] energy_bits;
	} request_t;

	typedef struct {
		logic [63:0] opacity;
		logic [3:0]  grp;
		logic        fin;
	} opacity_t;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 1200;
	localparam int FILL_TEMP = 3;
	localparam int FILL_DENS = 2;
	localparam int FILL_GROUPS = 2;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [1:0]  material;
	logic [2:0]  table_select;
	logic [4:0]  group;
	logic [3:0]  density_index;
	logic [3:0]  temp_index;
	logic [63:0] load_value;
	logic [63:0] density_bits;
	logic [63:0] temperature_bits;
	logic [63:0] energy_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] opacity_bits;
	logic [3:0]  group_index;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_data;

	log_bilinear_opacity_lookup_unit DUT (.*);

	request_t pending_requests[$];
	opacity_t expected_opacities[$];
	int       error_count;
	int       evals_sent;
	int       results_seen;
	int       idle_cycles;
	bit       req_taken;
	int       burst_left;
	int       gap_left;
	int       stall_phase;
	bit       only_first_mat;

	// Mirror of the block's tables and registers.
	logic [31:0] temp_grid[MATERIAL_SLOTS][MAX_TEMP_POINTS];
	logic [31:0] dens_grid[MATERIAL_SLOTS][MAX_DENSITY_POINTS];
	logic [63:0] bounds[MATERIAL_SLOTS][MAX_GROUPS + 1];
	logic [31:0] log_tab[MATERIAL_SLOTS][4][MAX_GROUPS][MAX_DENSITY_POINTS][MAX_TEMP_POINTS];
	logic [4:0]  temp_points_reg;
	logic [4:0]  dens_points_reg;
	logic [4:0]  group_count_reg;
	logic [63:0] sqrt2_chain[1:24];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] arg);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = arg;
		res = '0;
		b = 64'd1 << 62;
		while (b > x && b != 0)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint round_shift(input logic [63:0] p, input int s);
		logic [63:0] u;
		u = p + (64'd1 << 62) + (64'd1 << (s - 1));
		return longint'(u >> s) - (longint'(1) << (62 - s));
	endfunction

	function automatic longint ln_q24(input logic [63:0] b);
		logic [63:0] m;
		longint frac;
		longint l2;
		longint r;
		int e;
		e = int'(b[62:52]);
		frac = 0;
		if (b[63] || e == 0)
			return -64'sd2147483648;
		if (e == 2047)
			return 64'sd2147483647;
		m = (64'd1 << 30) | 64'(b[51:22]);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		l2 = longint'(e - 1023) * (longint'(1) << 24) + frac;
		r = round_shift(l2 * longint'(LN2_Q28), 28);
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		return r;
	endfunction

	function automatic logic [63:0] exp_double(input longint lv);
		longint y;
		longint k;
		logic [63:0] uy;
		logic [63:0] m;
		logic [63:0] ex;
		y = round_shift(lv * longint'(INV_LN2_Q30), 30);
		uy = y + (longint'(1) << 40);
		k = longint'(uy >> 24) - (longint'(1) << 16);
		m = 64'd1 << 31;
		for (int i = 1; i <= 24; i++)
			if (uy[24 - i])
				m = (m * sqrt2_chain[i]) >> 31;
		ex = k + 1023;
		return (ex << 52) | ((m - (64'd1 << 31)) << 21);
	endfunction

	function automatic int locate(input logic [63:0] keys[MAX_GROUPS + 1], input int n,
		input logic [63:0] x);
		if (x <= keys[0])
			return 0;
		if (x >= keys[n - 1])
			return n - 2;
		for (int i = 1; i < n; i++)
			if (keys[i] >= x)
				return i - 1;
		return n - 2;
	endfunction

	function automatic longint interp_weight(input longint v, input logic [31:0] lo,
		input logic [31:0] hi);
		longint num;
		longint den;
		num = v - longint'(signed'(lo));
		den = longint'(signed'(hi)) - longint'(signed'(lo));
		if (den <= 0 || num <= 0)
			return 0;
		if (num >= den)
			return 65536;
		return (num << 16) / den;
	endfunction

	function automatic int clamp_points(input logic [4:0] v, input int lo, input int hi);
		if (int'(v) < lo)
			return lo;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic logic [63:0] total_order_key(input logic [63:0] b);
		return b[63] ? ~b : (b | (64'd1 << 63));
	endfunction

	// Search a log grid and return the interval; the weight comes back in w.
	function automatic int grid_interval(input logic [31:0] g[16], input int n, input longint v,
		output longint w);
		logic [63:0] keys[MAX_GROUPS + 1];
		logic [31:0] vv;
		int id;
		for (int i = 0; i <= MAX_GROUPS; i++)
			keys[i] = '0;
		for (int i = 0; i < n; i++)
			keys[i] = 64'(g[i] ^ 32'h8000_0000);
		vv = v[31:0];
		id = locate(keys, n, 64'(vv ^ 32'h8000_0000));
		w = interp_weight(v, g[id], g[id + 1]);
		return id;
	endfunction

	task automatic apply_request(input request_t r);
		int nt;
		int nd;
		int ng;
		int tid;
		int rid;
		int gcount;
		int g;
		int plane;
		longint xi;
		longint eta;
		longint w[4];
		longint sum;
		logic [63:0] u;
		logic [63:0] keys[MAX_GROUPS + 1];
		opacity_t o;
		bit gray;
		plane = int'(r.table_select) - 3;
		if (r.command == CMD_LOAD_GRID) begin
			if (r.table_select == SEL_TEMP_GRID)
				temp_grid[r.material][r.temp_index] = r.load_value[31:0];
			else if (r.table_select == SEL_DENS_GRID)
				dens_grid[r.material][r.density_index] = r.load_value[31:0];
			else if (r.table_select == SEL_BOUNDS && r.group <= MAX_GROUPS)
				bounds[r.material][r.group] = r.load_value;
			return;
		end
		if (r.command == CMD_LOAD_TABLE) begin
			if (r.table_select >= SEL_ROSS_MG && r.table_select <= SEL_PLANCK_GRAY &&
					r.group < MAX_GROUPS)
				log_tab[r.material][plane][r.group][r.density_index][r.temp_index] =
					r.load_value[31:0];
			return;
		end
		if (r.table_select < SEL_ROSS_MG || r.table_select > SEL_PLANCK_GRAY)
			return;
		evals_sent++;
		gray = r.table_select >= SEL_ROSS_GRAY;
		nt = clamp_points(temp_points_reg, 2, MAX_TEMP_POINTS);
		nd = clamp_points(dens_points_reg, 2, MAX_DENSITY_POINTS);
		ng = clamp_points(group_count_reg, 1, MAX_GROUPS);
		tid = grid_interval(temp_grid[r.material], nt, ln_q24(r.temperature_bits), xi);
		rid = grid_interval(dens_grid[r.material], nd, ln_q24(r.density_bits), eta);
		w[0] = (65536 - xi) * (65536 - eta);
		w[1] = xi * (65536 - eta);
		w[2] = (65536 - xi) * eta;
		w[3] = xi * eta;
		g = 0;
		gcount = 1;
		if (r.command == CMD_EVAL_ALL) begin
			gcount = gray ? 1 : ng;
		end else if (!gray) begin
			for (int i = 0; i <= MAX_GROUPS; i++)
				keys[i] = (i <= ng) ? total_order_key(bounds[r.material][i]) : '0;
			g = locate(keys, ng + 1, total_order_key(r.energy_bits));
		end
		for (int c = 0; c < gcount; c++, g++) begin
			sum = longint'(signed'(log_tab[r.material][plane][g][rid][tid])) * w[0]
				+ longint'(signed'(log_tab[r.material][plane][g][rid][tid + 1])) * w[1]
				+ longint'(signed'(log_tab[r.material][plane][g][rid + 1][tid])) * w[2]
				+ longint'(signed'(log_tab[r.material][plane][g][rid + 1][tid + 1])) * w[3];
			u = (sum ^ (64'd1 << 63)) + (64'd1 << 31);
			o.opacity = exp_double(longint'(u >> 32) - (longint'(1) << 31));
			o.grp = g[3:0];
			o.fin = (c == gcount - 1);
			expected_opacities.push_back(o);
		end
	endtask

	// Rising edge: mirror accepted requests and writes, check results, watchdog.
	always @(posedge clk) begin
		opacity_t o;
		if (arst_n) begin
			req_taken = in_valid && in_ready;
			if (cfg_we) begin
				if (cfg_index == REG_TEMP_POINTS)
					temp_points_reg = cfg_data;
				else if (cfg_index == REG_DENS_POINTS)
					dens_points_reg = cfg_data;
				else if (cfg_index == REG_GROUP_COUNT)
					group_count_reg = cfg_data;
			end
			if (req_taken)
				apply_request('{cmd_t'(command), material, table_select, group, density_index,
					temp_index, load_value, density_bits, temperature_bits, energy_bits});
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_opacities.size() == 0) begin
					$error("unexpected result: opacity_bits %h group_index %0d last %0d",
						opacity_bits, group_index, last);
					error_count++;
				end else begin
					o = expected_opacities.pop_front();
					if (opacity_bits !== o.opacity) begin
						$error("opacity_bits: expected %h, actual %h", o.opacity, opacity_bits);
						error_count++;
					end
					if (group_index !== o.grp) begin
						$error("group_index: expected %0d, actual %0d", o.grp, group_index);
						error_count++;
					end
					if (last !== o.fin) begin
						$error("last: expected %0d, actual %0d", o.fin, last);
						error_count++;
					end
				end
			end
			if (req_taken || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Falling edge: request driver working in bursts.
	always @(negedge clk) begin
		request_t r;
		bit nv;
		if (arst_n && (!in_valid || req_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_requests.size() != 0) begin
				r = pending_requests.pop_front();
				nv = 1'b1;
				command <= r.command;
				material <= r.material;
				table_select <= r.table_select;
				group <= r.group;
				density_index <= r.density_index;
				temp_index <= r.temp_index;
				load_value <= r.load_value;
				density_bits <= r.density_bits;
				temperature_bits <= r.temperature_bits;
				energy_bits <= r.energy_bits;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			in_valid <= nv;
			req_taken = 1'b0;
		end
	end

	// Falling edge: result receiver, cycling through stall patterns.
	always @(negedge clk) begin
		stall_phase++;
		case (stall_phase[12:11])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= stall_phase[1:0] != 2'd0;
			2'd2: out_ready <= 1'($urandom_range(1));
			default: out_ready <= stall_phase[4:0] < 5'd4;
		endcase
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic request_t base_request(input cmd_t c, input logic [2:0] sel);
		request_t r;
		r.command = c;
		r.material = $urandom_range(3);
		r.table_select = sel;
		r.group = $urandom_range(31);
		r.density_index = $urandom_range(15);
		r.temp_index = $urandom_range(15);
		r.load_value = rand64();
		r.density_bits = rand64();
		r.temperature_bits = rand64();
		r.energy_bits = rand64();
		return r;
	endfunction

	// A positive double whose log mostly lands in or near the grid span.
	function automatic logic [63:0] physical_double();
		logic [63:0] d;
		d = rand64();
		d[63] = 1'b0;
		d[62:52] = 11'($urandom_range(1023 - 14, 1023 + 17));
		return d;
	endfunction

	function automatic logic [63:0] odd_double();
		logic [63:0] d;
		d = rand64();
		case ($urandom_range(5))
			0: d = '0;
			1: d[63] = 1'b1;
			2: d[62:52] = '0;
			3: d[62:52] = '1;
			4: d = {1'b0, 11'h7FF, 52'd0};
			default: d[63] = 1'b0;
		endcase
		return d;
	endfunction

	// Evaluations only address materials whose grids and tables have been filled.
	function automatic request_t eval_request();
		request_t r;
		logic [2:0] sel;
		int pick;
		sel = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3, 6));
		r = base_request($urandom_range(1) ? CMD_EVAL_ALL : CMD_EVAL_AT, sel);
		r.material = (only_first_mat || $urandom_range(1) == 0) ? 2'd0 : 2'd3;
		r.density_bits = ($urandom_range(9) == 0) ? odd_double() : physical_double();
		r.temperature_bits = ($urandom_range(9) == 0) ? odd_double() : physical_double();
		pick = $urandom_range(FILL_GROUPS);
		if ($urandom_range(7) == 0)
			r.energy_bits = odd_double();
		else
			r.energy_bits = bounds[r.material][pick] + 64'($urandom) - 64'(32'h8000_0000);
		return r;
	endfunction

	function automatic request_t load_request();
		request_t r;
		r = base_request($urandom_range(1) ? CMD_LOAD_GRID : CMD_LOAD_TABLE,
			3'($urandom_range(7)));
		if ($urandom_range(1))
			r.load_value[31:0] = 32'($urandom_range(0, 40 << 24)) - 32'(20 << 24);
		return r;
	endfunction

	function automatic request_t table_entry(input logic [1:0] m, input int t, input int g,
		input int d, input int k);
		request_t r;
		r = base_request(CMD_LOAD_TABLE, 3'(t + 3));
		r.material = m;
		r.group = 5'(g);
		r.density_index = 4'(d);
		r.temp_index = 4'(k);
		if ($urandom_range(7) != 0)
			r.load_value[31:0] = 32'($urandom_range(0, 40 << 24)) - 32'(20 << 24);
		return r;
	endfunction

	task automatic fill_material(input logic [1:0] m);
		request_t r;
		logic [31:0] tv;
		logic [31:0] dv;
		logic [63:0] bv;
		tv = 32'($urandom_range(0, 4 << 24)) - 32'(7 << 24);
		dv = 32'($urandom_range(0, 4 << 24)) - 32'(8 << 24);
		bv = {12'h3F0, 52'($urandom)};
		for (int i = 0; i < FILL_TEMP; i++) begin
			r = base_request(CMD_LOAD_GRID, SEL_TEMP_GRID);
			r.material = m;
			r.temp_index = 4'(i);
			r.load_value[31:0] = tv;
			pending_requests.push_back(r);
			tv = tv + 32'($urandom_range(1 << 22, 3 << 24));
		end
		for (int i = 0; i < FILL_DENS; i++) begin
			r = base_request(CMD_LOAD_GRID, SEL_DENS_GRID);
			r.material = m;
			r.density_index = 4'(i);
			r.load_value[31:0] = dv;
			pending_requests.push_back(r);
			dv = dv + 32'($urandom_range(1 << 22, 3 << 24));
		end
		for (int i = 0; i <= FILL_GROUPS; i++) begin
			r = base_request(CMD_LOAD_GRID, SEL_BOUNDS);
			r.material = m;
			r.group = 5'(i);
			r.load_value = bv;
			pending_requests.push_back(r);
			bv = bv + {12'd0, 3'($urandom_range(1, 7)), 49'($urandom)};
		end
		for (int t = 0; t < 4; t++)
			for (int g = 0; g < FILL_GROUPS; g++)
				for (int d = 0; d < FILL_DENS; d++)
					for (int k = 0; k < FILL_TEMP; k++)
						pending_requests.push_back(table_entry(m, t, g, d, k));
	endtask

	// Grows the first material's temperature grid to its full length for group 0.
	task automatic extend_temp_grid();
		request_t r;
		logic [31:0] tv;
		tv = temp_grid[0][FILL_TEMP - 1];
		for (int i = FILL_TEMP; i < MAX_TEMP_POINTS; i++) begin
			tv = tv + 32'($urandom_range(1 << 22, 3 << 24));
			r = base_request(CMD_LOAD_GRID, SEL_TEMP_GRID);
			r.material = 2'd0;
			r.temp_index = 4'(i);
			r.load_value[31:0] = tv;
			pending_requests.push_back(r);
			for (int t = 0; t < 4; t++)
				for (int d = 0; d < FILL_DENS; d++)
					pending_requests.push_back(table_entry(2'd0, t, 0, d, i));
		end
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || in_valid || expected_opacities.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_requests();
		request_t r;
		for (int s = 3; s <= 6; s++) begin
			r = eval_request();
			r.command = CMD_EVAL_ALL;
			r.table_select = 3'(s);
			pending_requests.push_back(r);
			r.command = CMD_EVAL_AT;
			pending_requests.push_back(r);
		end
		for (int s = 0; s <= 7; s += 7) begin
			r = eval_request();
			r.table_select = 3'(s);
			pending_requests.push_back(r);
		end
		r = eval_request();
		r.command = CMD_EVAL_ALL;
		r.table_select = SEL_ROSS_MG;
		r.density_bits = '0;
		r.temperature_bits = {1'b1, 63'h3FF0_0000_0000_0000};
		pending_requests.push_back(r);
		r.density_bits = {12'h000, 52'h1};
		r.temperature_bits = {1'b0, 11'h7FF, 52'd0};
		pending_requests.push_back(r);
		r.density_bits = {1'b0, 11'h7FF, 52'h8_0000_0000_0001};
		r.temperature_bits = {1'b0, 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
		pending_requests.push_back(r);
		r.command = CMD_EVAL_AT;
		r.table_select = SEL_PLANCK_MG;
		r.density_bits = physical_double();
		r.temperature_bits = physical_double();
		r.energy_bits = 64'h8000_0000_0000_0000;
		pending_requests.push_back(r);
		r.energy_bits = '0;
		pending_requests.push_back(r);
		r.energy_bits = 64'h7FF8_0000_0000_0000;
		pending_requests.push_back(r);
		r.energy_bits = 64'hFFFF_FFFF_FFFF_FFFF;
		pending_requests.push_back(r);
		r.table_select = SEL_ROSS_GRAY;
		pending_requests.push_back(r);
		r = load_request();
		r.command = CMD_LOAD_GRID;
		r.table_select = 3'd7;
		pending_requests.push_back(r);
		r.command = CMD_LOAD_TABLE;
		r.table_select = SEL_ROSS_MG;
		r.group = 5'd16;
		pending_requests.push_back(r);
		r.command = CMD_LOAD_GRID;
		r.table_select = SEL_BOUNDS;
		r.group = 5'd31;
		pending_requests.push_back(r);
	endtask

	task automatic random_requests(input int n);
		for (int i = 0; i < n; i++)
			pending_requests.push_back(($urandom_range(9) < 7) ? eval_request() : load_request());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_LOAD_GRID;
		material = '0;
		table_select = '0;
		group = '0;
		density_index = '0;
		temp_index = '0;
		load_value = '0;
		density_bits = '0;
		temperature_bits = '0;
		energy_bits = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_POINTS;
		cfg_data = '0;
		error_count = 0;
		evals_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		req_taken = 1'b0;
		burst_left = 1;
		gap_left = 0;
		only_first_mat = 1'b0;
		stall_phase = $urandom_range(8191);
		temp_points_reg = 5'd16;
		dens_points_reg = 5'd16;
		group_count_reg = 5'd16;
		begin
			logic [63:0] c;
			c = 64'd1 << 32;
			for (int i = 1; i <= 24; i++) begin
				c = int_sqrt(c << 31);
				sqrt2_chain[i] = c;
			end
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_TEMP_POINTS, 5'(FILL_TEMP));
		write_reg(REG_DENS_POINTS, 5'(FILL_DENS));
		write_reg(REG_GROUP_COUNT, 5'(FILL_GROUPS));
		fill_material(2'd0);
		fill_material(2'd3);
		drain();
		directed_requests();
		random_requests(40);
		drain();
		write_reg(REG_TEMP_POINTS, 5'd2);
		write_reg(REG_DENS_POINTS, 5'd2);
		write_reg(REG_GROUP_COUNT, 5'd1);
		random_requests(40);
		drain();
		write_reg(REG_TEMP_POINTS, 5'd31);
		write_reg(REG_DENS_POINTS, 5'd0);
		write_reg(REG_GROUP_COUNT, 5'd0);
		only_first_mat = 1'b1;
		extend_temp_grid();
		random_requests(20);
		drain();
		only_first_mat = 1'b0;
		write_reg(REG_TEMP_POINTS, 5'($urandom_range(0, FILL_TEMP)));
		write_reg(REG_DENS_POINTS, 5'($urandom_range(0, FILL_DENS)));
		write_reg(REG_GROUP_COUNT, 5'($urandom_range(0, FILL_GROUPS)));
		random_requests(20);
		drain();

		$display("Covered table fills, %0d evaluation requests and %0d results", evals_sent,
			results_seen);
		$display("across four register settings, out-of-grid and special double inputs.");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
